// ----- src/lcs_pkg.sv -----
// Shared types and constants for the LCS length engine.
// Depends on nothing; every other file of the block depends on it.
package lcs_pkg;

    localparam int LCS_MAX_FIRST_LEN = 256;
    localparam int LCS_BYTE_W        = 8;
    localparam int LCS_LEN_W         = 9;
    localparam int LCS_LEN_MAX       = 511;

    // Codes of the kind field.
    localparam logic LCS_KIND_FIRST  = 1'b0;
    localparam logic LCS_KIND_SECOND = 1'b1;

    // Control part of an item as it travels down the cell chain.
    // need is set while a first-sequence byte still looks for a free cell.
    typedef struct packed {
        logic                  valid;
        logic                  kind;
        logic [LCS_BYTE_W-1:0] byte_value;
        logic                  last;
        logic                  need;
    } lcs_token_t;

endpackage

// ----- src/lcs_in_if.sv -----
// Input channel of the LCS length engine: valid/ready plus the item fields.
// Depends on lcs_pkg for the byte width.
interface lcs_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [lcs_pkg::LCS_BYTE_W-1:0] byte_value;
    logic                          last;

    modport source (output valid, output kind, output byte_value, output last, input ready);
    modport sink   (input valid, input kind, input byte_value, input last, output ready);
endinterface

// ----- src/lcs_out_if.sv -----
// Result channel of the LCS length engine: valid/ready plus the result fields.
// Depends on lcs_pkg for the length width.
interface lcs_out_if;
    logic                         valid;
    logic                         ready;
    logic [lcs_pkg::LCS_LEN_W-1:0] lcs_length;
    logic                         overflow;

    modport source (output valid, output lcs_length, output overflow, input ready);
    modport sink   (input valid, input lcs_length, input overflow, output ready);
endinterface

// ----- src/lcs_cell.sv -----
// One cell of the systolic chain: holds one stored byte and its row score.
// Depends on lcs_pkg for the token type and kind codes.
module lcs_cell #(
    parameter int SCORE_W = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  lcs_pkg::lcs_token_t tok_in,
    input  logic [SCORE_W-1:0]  left_in,
    input  logic [SCORE_W-1:0]  diag_in,
    output lcs_pkg::lcs_token_t tok_out,
    output logic [SCORE_W-1:0]  left_out,
    output logic [SCORE_W-1:0]  diag_out
);
    import lcs_pkg::*;

    lcs_token_t            tok_reg, tok_next;
    logic [SCORE_W-1:0]    left_reg, left_next;
    logic [SCORE_W-1:0]    diag_reg, diag_next;
    logic [SCORE_W-1:0]    score_reg, score_next;
    logic [LCS_BYTE_W-1:0] byte_reg, byte_next;
    logic                  occ_reg, occ_next;
    logic [SCORE_W-1:0]    cand;

    always_comb
    begin
        if (byte_reg == tok_in.byte_value)
            cand = diag_in + SCORE_W'(1);
        else if (score_reg > left_in)
            cand = score_reg;
        else
            cand = left_in;
    end

    always_comb
    begin
        tok_next   = tok_in;
        left_next  = left_in;
        diag_next  = score_reg;
        occ_next   = occ_reg;
        score_next = score_reg;
        byte_next  = byte_reg;
        if (tok_in.valid)
        begin
            if (tok_in.kind == LCS_KIND_SECOND)
            begin
                if (occ_reg)
                begin
                    left_next  = cand;
                    score_next = cand;
                end
            end
            else
            begin
                if (occ_reg)
                    left_next = score_reg;
                else if (tok_in.need)
                begin
                    byte_next     = tok_in.byte_value;
                    score_next    = '0;
                    left_next     = '0;
                    occ_next      = 1'b1;
                    tok_next.need = 1'b0;
                end
            end
            // The end of a pair empties the cell once it has been used.
            if (tok_in.last)
                occ_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            occ_reg <= 1'b0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_reg  <= left_next;
            diag_reg  <= diag_next;
            score_reg <= score_next;
            byte_reg  <= byte_next;
        end
    end

    assign tok_out  = tok_reg;
    assign left_out = left_reg;
    assign diag_out = diag_reg;

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && tok_in.valid && tok_in.last |=> !occ_reg)
        else $error("cell still occupied after end of pair");

    a_store_once: assert property (@(posedge clk) disable iff (!rst_n)
        advance && tok_in.valid && tok_in.need && !occ_reg && !tok_in.last
        |=> occ_reg && !tok_reg.need)
        else $error("free cell did not take a first-sequence byte");

    a_need_first: assert property (@(posedge clk) disable iff (!rst_n)
        tok_reg.valid && tok_reg.need |-> tok_reg.kind == LCS_KIND_FIRST)
        else $error("placement request on a second-sequence item");

endmodule

// ----- src/lcs_tail.sv -----
// End of the cell chain: overflow tracking and the registered result.
// Depends on lcs_pkg and on the lcs_out_if interface.
module lcs_tail #(
    parameter int SCORE_W = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lcs_pkg::lcs_token_t tok_in,
    input  logic [SCORE_W-1:0]  left_in,
    output logic                advance,
    lcs_out_if.source           result
);
    import lcs_pkg::*;

    localparam int CMP_W = (SCORE_W > LCS_LEN_W) ? SCORE_W : LCS_LEN_W;

    logic                 out_valid_reg;
    logic [LCS_LEN_W-1:0] len_reg;
    logic                 ovf_reg;
    logic                 ovf_flag_reg;
    logic                 drop;
    logic                 finish;
    logic [CMP_W-1:0]     wide_len;
    logic [LCS_LEN_W-1:0] sat_len;

    // The chain only stalls when a result is due and the last one is still held.
    assign advance = !(tok_in.valid && tok_in.last && out_valid_reg && !result.ready);
    assign drop    = tok_in.valid && (tok_in.kind == LCS_KIND_FIRST) && tok_in.need;
    assign finish  = advance && tok_in.valid && tok_in.last;

    always_comb
    begin
        wide_len = CMP_W'(left_in);
        if (wide_len > CMP_W'(LCS_LEN_MAX))
            sat_len = LCS_LEN_W'(LCS_LEN_MAX);
        else
            sat_len = LCS_LEN_W'(wide_len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ovf_flag_reg  <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                ovf_flag_reg  <= 1'b0;
            end
            else
            begin
                if (result.ready)
                    out_valid_reg <= 1'b0;
                if (advance && drop)
                    ovf_flag_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            len_reg <= sat_len;
            ovf_reg <= ovf_flag_reg | drop;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.lcs_length = len_reg;
    assign result.overflow   = ovf_reg;

    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg && !ovf_flag_reg)
        else $error("end of pair did not raise a result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |-> out_valid_reg && tok_in.last)
        else $error("chain stalled without a pending result");

    a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        advance && drop && !tok_in.last |=> ovf_flag_reg)
        else $error("dropped first-sequence byte not flagged");

endmodule

// ----- src/lcs_length_engine.sv -----
// Top level of the LCS length engine: a chain of scoring cells and a result tail.
// Depends on lcs_pkg, lcs_in_if, lcs_out_if, lcs_cell and lcs_tail.
//
// The engine computes the length of the longest common subsequence of two byte
// sequences. Bytes of the first sequence (kind 0) settle, in order, into a chain
// of MAX_FIRST_LEN cells; a byte that finds every cell taken is dropped and the
// overflow bit of the result is set. Bytes of the second sequence (kind 1) flow
// down the same chain as a systolic wavefront: each cell updates its score from
// its own old score, its left neighbor's new score and its left neighbor's old
// score, one cell per clock. Every item, of either kind, travels the full chain,
// so the order of items is kept exactly. The item that carries last produces one
// result at the end of the chain and empties each cell as it passes, so the next
// pair may follow directly behind it. The engine accepts one item per clock;
// an item's effect passes through each cell register of the chain and the result
// register of the tail before it reaches the output. The whole chain stalls
// only while a result is due and the previous result still waits to be taken.
// Scores above 511 are reported as 511.
module lcs_length_engine #(
    parameter int MAX_FIRST_LEN = lcs_pkg::LCS_MAX_FIRST_LEN
) (
    input  logic      clk,
    input  logic      rst_n,
    lcs_in_if.sink    item,
    lcs_out_if.source result
);
    import lcs_pkg::*;

    // A score never exceeds the number of cells.
    localparam int SCORE_W = $clog2(MAX_FIRST_LEN + 1);

    lcs_token_t         tok_chain  [0:MAX_FIRST_LEN];
    logic [SCORE_W-1:0] left_chain [0:MAX_FIRST_LEN];
    logic [SCORE_W-1:0] diag_chain [0:MAX_FIRST_LEN];
    logic               advance;

    // The head of the chain: an accepted transfer enters cell 0. Since ready
    // equals advance, the valid bit of the head token marks a transfer.
    always_comb
    begin
        tok_chain[0].valid      = item.valid;
        tok_chain[0].kind       = item.kind;
        tok_chain[0].byte_value = item.byte_value;
        tok_chain[0].last       = item.last;
        tok_chain[0].need       = (item.kind == LCS_KIND_FIRST);
    end

    // Left of the first cell, both the new and the diagonal score are zero.
    assign left_chain[0] = '0;
    assign diag_chain[0] = '0;
    assign item.ready    = advance;

    for (genvar i = 0; i < MAX_FIRST_LEN; i++)
    begin : g_cell
        lcs_cell #(
            .SCORE_W (SCORE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .tok_in   (tok_chain[i]),
            .left_in  (left_chain[i]),
            .diag_in  (diag_chain[i]),
            .tok_out  (tok_chain[i+1]),
            .left_out (left_chain[i+1]),
            .diag_out (diag_chain[i+1])
        );
    end

    // The left score leaving the chain is the score of the last occupied cell,
    // or zero when no byte of the first sequence is stored.
    lcs_tail #(
        .SCORE_W (SCORE_W)
    ) u_tail (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_in  (tok_chain[MAX_FIRST_LEN]),
        .left_in (left_chain[MAX_FIRST_LEN]),
        .advance (advance),
        .result  (result)
    );

endmodule

// ----- test/tb_lcs_length_engine.sv -----
// Self-checking testbench for lcs_length_engine: directed pairs, capacity edges, random pairs.
// Depends on lcs_pkg, lcs_in_if, lcs_out_if and the engine itself; predicts results on its own.
// Items are driven at the falling edge, transfers and results are sampled at the rising edge.
module tb_lcs_length_engine;
    import lcs_pkg::*;

    localparam int CHAIN_LATENCY   = LCS_MAX_FIRST_LEN + 1;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int RUN_LIMIT       = 1_000_000;

    typedef struct packed {
        logic [LCS_LEN_W-1:0] lcs_length;
        logic                 overflow;
    } lcs_result_t;

    logic clk = 1'b0;
    logic rst_n;

    lcs_in_if  item_if ();
    lcs_out_if result_if ();

    lcs_length_engine #(
        .MAX_FIRST_LEN(LCS_MAX_FIRST_LEN)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_if),
        .result(result_if)
    );

    always #1 clk = ~clk;

    // Shadow copy of the engine's contents: stored first-sequence bytes, the current
    // score row, how many bytes are stored and whether any were dropped.
    logic [LCS_BYTE_W-1:0] stored_bytes [LCS_MAX_FIRST_LEN];
    int                    row_score    [LCS_MAX_FIRST_LEN];
    int                    stored_count = 0;
    logic                  bytes_dropped = 1'b0;

    lcs_result_t pending_results [$];

    int send_gap_pct  = 0;
    int take_gap_pct  = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int overflow_seen = 0;
    int longest_seen  = 0;
    int error_count   = 0;

    // Applies one accepted item to the shadow state and, if it carries last, queues the expected result.
    function automatic void predict_lcs(logic k, logic [LCS_BYTE_W-1:0] b, logic is_last);
        int diag;
        int left_new;
        int above;
        int new_score;
        int i;
        lcs_result_t res;
        if (k == LCS_KIND_FIRST) begin
            if (stored_count < LCS_MAX_FIRST_LEN) begin
                stored_bytes[stored_count] = b;
                row_score[stored_count] = 0;
                stored_count++;
            end
            else begin
                bytes_dropped = 1'b1;
            end
        end
        else begin
            // One row of the score table: a match extends the diagonal, a miss
            // keeps the better of the cell above and the freshly updated left cell.
            diag = 0;
            left_new = 0;
            for (i = 0; i < stored_count; i++) begin
                above = row_score[i];
                if (stored_bytes[i] == b)
                    new_score = diag + 1;
                else
                    new_score = (above > left_new) ? above : left_new;
                row_score[i] = new_score;
                diag = above;
                left_new = new_score;
            end
        end
        if (is_last) begin
            res.lcs_length = '0;
            if (stored_count > 0)
                res.lcs_length = (row_score[stored_count-1] > LCS_LEN_MAX) ?
                                 LCS_LEN_W'(LCS_LEN_MAX) :
                                 LCS_LEN_W'(row_score[stored_count-1]);
            res.overflow = bytes_dropped;
            pending_results.push_back(res);
            for (i = 0; i < LCS_MAX_FIRST_LEN; i++)
                row_score[i] = 0;
            stored_count = 0;
            bytes_dropped = 1'b0;
        end
    endfunction

    // Offers one item, with random gaps before it, and returns at the falling edge
    // after its transfer with valid still high.
    task automatic send_item(input logic k, input logic [LCS_BYTE_W-1:0] b, input logic is_last);
        while ($urandom_range(99) < send_gap_pct) begin
            item_if.valid      <= 1'b0;
            item_if.kind       <= 1'($urandom_range(1));
            item_if.byte_value <= LCS_BYTE_W'($urandom_range(255));
            item_if.last       <= 1'($urandom_range(1));
            @(negedge clk);
        end
        item_if.valid      <= 1'b1;
        item_if.kind       <= k;
        item_if.byte_value <= b;
        item_if.last       <= is_last;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        predict_lcs(k, b, is_last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_results_drained;
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // A pair with random lengths; most use a small alphabet so that matches are
    // common, some interleave the two sequences in any order.
    task automatic send_random_pair(input int max_len);
        int n_first;
        int total;
        int idx;
        int j;
        bit mixed;
        bit full_range;
        logic k;
        logic [LCS_BYTE_W-1:0] symbols [4];
        logic [LCS_BYTE_W-1:0] b;
        n_first = $urandom_range(max_len);
        total = n_first + $urandom_range(max_len);
        if (total == 0)
            total = 1;
        mixed = ($urandom_range(7) == 0);
        full_range = ($urandom_range(3) == 0);
        for (j = 0; j < 4; j++)
            symbols[j] = LCS_BYTE_W'($urandom_range(255));
        for (idx = 0; idx < total; idx++) begin
            if (mixed)
                k = $urandom_range(1) ? LCS_KIND_SECOND : LCS_KIND_FIRST;
            else
                k = (idx < n_first) ? LCS_KIND_FIRST : LCS_KIND_SECOND;
            b = full_range ? LCS_BYTE_W'($urandom_range(255)) : symbols[2'($urandom_range(3))];
            send_item(k, b, idx == total - 1);
        end
    endtask

    task automatic test_directed_cases;
        // Empty pair: last arrives with nothing stored.
        send_item(LCS_KIND_SECOND, 8'h00, 1'b1);
        // Last on a first-sequence byte that is the only item of its pair.
        send_item(LCS_KIND_FIRST, 8'hFF, 1'b1);
        // Extreme byte values crossed over.
        send_item(LCS_KIND_FIRST, 8'h00, 1'b0);
        send_item(LCS_KIND_FIRST, 8'hFF, 1'b0);
        send_item(LCS_KIND_SECOND, 8'hFF, 1'b0);
        send_item(LCS_KIND_SECOND, 8'h00, 1'b1);
        // A first byte appended after second bytes starts from a zero cell.
        send_item(LCS_KIND_FIRST, 8'hAA, 1'b0);
        send_item(LCS_KIND_SECOND, 8'hAA, 1'b0);
        send_item(LCS_KIND_FIRST, 8'hAA, 1'b0);
        send_item(LCS_KIND_SECOND, 8'h55, 1'b1);
        // Last on a first byte that follows second bytes.
        send_item(LCS_KIND_FIRST, 8'h12, 1'b0);
        send_item(LCS_KIND_SECOND, 8'h12, 1'b0);
        send_item(LCS_KIND_FIRST, 8'h34, 1'b1);
        // Second bytes with an empty first sequence.
        send_item(LCS_KIND_SECOND, 8'h01, 1'b0);
        send_item(LCS_KIND_SECOND, 8'h80, 1'b1);
        // Identical short sequences.
        send_item(LCS_KIND_FIRST, 8'h5A, 1'b0);
        send_item(LCS_KIND_FIRST, 8'hA5, 1'b0);
        send_item(LCS_KIND_FIRST, 8'h3C, 1'b0);
        send_item(LCS_KIND_SECOND, 8'h5A, 1'b0);
        send_item(LCS_KIND_SECOND, 8'hA5, 1'b0);
        send_item(LCS_KIND_SECOND, 8'h3C, 1'b1);
        wait_results_drained();
    endtask

    // Fills every cell and matches it in full, then overruns the capacity,
    // ending that pair on a first byte that is itself dropped.
    task automatic test_capacity_limits;
        logic [LCS_BYTE_W-1:0] symbols [4];
        logic [LCS_BYTE_W-1:0] pattern [LCS_MAX_FIRST_LEN];
        int i;
        for (i = 0; i < 4; i++)
            symbols[i] = LCS_BYTE_W'($urandom_range(255));
        for (i = 0; i < LCS_MAX_FIRST_LEN; i++) begin
            pattern[i] = symbols[2'($urandom_range(3))];
            send_item(LCS_KIND_FIRST, pattern[i], 1'b0);
        end
        for (i = 0; i < LCS_MAX_FIRST_LEN; i++)
            send_item(LCS_KIND_SECOND, pattern[i], i == LCS_MAX_FIRST_LEN - 1);
        wait_results_drained();
        for (i = 0; i < LCS_MAX_FIRST_LEN + 2; i++)
            send_item(LCS_KIND_FIRST, symbols[2'($urandom_range(3))], 1'b0);
        for (i = 0; i < 3; i++)
            send_item(LCS_KIND_SECOND, symbols[2'($urandom_range(3))], 1'b0);
        send_item(LCS_KIND_FIRST, LCS_BYTE_W'($urandom_range(255)), 1'b1);
        wait_results_drained();
    endtask

    task automatic test_random_pairs(input int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target)
            send_random_pair(($urandom_range(9) == 0) ? 40 : 12);
        wait_results_drained();
    endtask

    // The result side stops taking for a long stretch while short pairs keep
    // coming, so two results meet at the end of the chain and the input stalls.
    task automatic test_output_backpressure;
        int target;
        hold_req++;
        target = items_sent + 160;
        while (items_sent < target)
            send_random_pair(6);
        wait_results_drained();
    endtask

    // Result side: random stalls, overridden by a counted hold-off on request.
    always @(negedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_if.ready <= 1'b0;
        end
        else begin
            result_if.ready <= ($urandom_range(99) >= take_gap_pct);
        end
    end

    // Each result transfer is matched against the oldest expected length.
    always @(posedge clk) begin
        lcs_result_t want;
        if (rst_n && result_if.valid && result_if.ready) begin
            results_seen++;
            if (result_if.overflow === 1'b1)
                overflow_seen++;
            if (int'(result_if.lcs_length) > longest_seen)
                longest_seen = int'(result_if.lcs_length);
            if (pending_results.size() == 0) begin
                $error("unexpected result: lcs_length %0d, overflow %0b",
                       result_if.lcs_length, result_if.overflow);
                error_count++;
            end
            else begin
                want = pending_results.pop_front();
                if (result_if.lcs_length !== want.lcs_length) begin
                    $error("lcs_length mismatch: expected %0d, actual %0d",
                           want.lcs_length, result_if.lcs_length);
                    error_count++;
                end
                if (result_if.overflow !== want.overflow) begin
                    $error("overflow mismatch: expected %0b, actual %0b",
                           want.overflow, result_if.overflow);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        rst_n              = 1'b0;
        item_if.valid      = 1'b0;
        item_if.kind       = LCS_KIND_FIRST;
        item_if.byte_value = '0;
        item_if.last       = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        send_gap_pct = 22;
        take_gap_pct = 88;
        test_directed_cases();
        test_random_pairs(150);

        send_gap_pct = 88;
        take_gap_pct = 22;
        test_capacity_limits();
        test_random_pairs(60);

        send_gap_pct = 0;
        take_gap_pct = 0;
        test_output_backpressure();
        test_random_pairs(60);

        repeat (CHAIN_LATENCY + 16) @(posedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        $display("Sent %0d items and checked %0d results (%0d with overflow, longest %0d).",
                 items_sent, results_seen, overflow_seen, longest_seen);
        $display("Covered empty and mixed pairs, full capacity, overrun and output hold-off.");
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
